FILE: sv/imgup_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image upscaler package
// Types, codes and fixed field widths shared by the upscaler modules.
// ----------------------------------------------------------------------------
package imgup_pkg;

	localparam int COORD_W     = 9;
	localparam int PIX_W       = 8;
	localparam int DIM_W       = 7;
	localparam int SCALE_W     = 2;
	localparam int GAIN_W      = 12;
	localparam int FRAC_MAX    = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int QUEUE_DEPTH = 4;
	// Width of (width << scale) - 1 at the largest scale.
	localparam int SPAN_W      = DIM_W + (1 << SCALE_W) - 1;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		M_NEAREST   = 2'd0,
		M_BILINEAR  = 2'd1,
		M_QUADRATIC = 2'd2,
		M_BARY      = 2'd3
	} method_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_SCALE  = 3'd2,
		REG_METHOD = 3'd3,
		REG_GAIN   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MAP,
		F_DIV,
		F_EMIT
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_PREP,
		B_READ,
		B_DRAIN
	} back_state_t;

	typedef struct packed {
		logic               operation;
		logic [COORD_W-1:0] x_pos;
		logic [COORD_W-1:0] y_pos;
		logic [PIX_W-1:0]   pixel;
	} in_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] intensity;
		logic             clipped;
	} out_word_t;

	// Effective configuration, dimensions already limited to 1..MAX.
	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [SCALE_W-1:0] scale;
		method_t            method;
		logic [GAIN_W-1:0]  gain;
	} cfg_t;

	// One classified word between the front and the back.
	typedef struct packed {
		op_t                 kind;
		method_t             mth;
		logic [COORD_W-1:0]  xi;
		logic [COORD_W-1:0]  yi;
		logic [FRAC_MAX-1:0] fx;
		logic [FRAC_MAX-1:0] fy;
		logic [PIX_W-1:0]    pixel;
	} entry_t;

endpackage

FILE: sv/imgup_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image upscaler divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imgup_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 10,
	parameter int QUO_W = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] sh_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// The quotient is known to fit QUO_W bits, so the upper part of the
	// numerator is already below the divisor and seeds the remainder.
	assign trial = {rem_q, sh_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> QUO_W);
			sh_q  <= num[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
			sh_q  <= {sh_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule

FILE: sv/imgup_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image upscaler front
// Accepts words, clamps sample positions and maps them to source coordinates.
// ----------------------------------------------------------------------------
module imgup_front #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int FRAC_BITS  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  imgup_pkg::cfg_t    cfg,
	input  logic               push,
	output logic               full,
	input  imgup_pkg::in_word_t item,
	output logic               q_push,
	input  logic               q_full,
	output imgup_pkg::entry_t  q_data
);
	import imgup_pkg::*;

	localparam int POS_W = DIM_W + FRAC_BITS;
	localparam int NUM_W = COORD_W + DIM_W + FRAC_BITS;

	front_state_t       state_q, state_d;
	entry_t             ent_q;
	logic [COORD_W-1:0] xc_q, yc_q;
	logic               accept;
	logic               in_store;
	logic               div_start;
	logic               done_x, done_y;
	logic [POS_W-1:0]   pos_x, pos_y;
	logic [SPAN_W-1:0]  lim_x, lim_y;
	logic [COORD_W-1:0] xc, yc;
	logic [NUM_W-1:0]   num_x, num_y;

	assign accept   = push && !full;
	assign in_store = (int'(item.x_pos) < MAX_WIDTH) && (int'(item.y_pos) < MAX_HEIGHT);

	// Last output column and row; also the divisors of the position map.
	assign lim_x = (SPAN_W'(cfg.width) << cfg.scale) - SPAN_W'(1);
	assign lim_y = (SPAN_W'(cfg.height) << cfg.scale) - SPAN_W'(1);
	assign xc    = (SPAN_W'(item.x_pos) > lim_x) ? lim_x[COORD_W-1:0] : item.x_pos;
	assign yc    = (SPAN_W'(item.y_pos) > lim_y) ? lim_y[COORD_W-1:0] : item.y_pos;

	assign num_x = (NUM_W'(xc_q) * NUM_W'(cfg.width - DIM_W'(1))) << FRAC_BITS;
	assign num_y = (NUM_W'(yc_q) * NUM_W'(cfg.height - DIM_W'(1))) << FRAC_BITS;

	imgup_div #(.NUM_W(NUM_W), .DEN_W(SPAN_W), .QUO_W(POS_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_x), .den(lim_x), .done(done_x), .quo(pos_x)
	);

	imgup_div #(.NUM_W(NUM_W), .DEN_W(SPAN_W), .QUO_W(POS_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_y), .den(lim_y), .done(done_y), .quo(pos_y)
	);

	// Both dividers run in lock step, so they finish in the same cycle.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (item.operation == OP_LOAD) begin
						state_d = in_store ? F_EMIT : F_IDLE;
					end else begin
						state_d = (cfg.method == M_NEAREST) ? F_EMIT : F_MAP;
					end
				end
			end
			F_MAP:  state_d = F_DIV;
			F_DIV:  if (done_x && done_y) state_d = F_EMIT;
			F_EMIT: if (!q_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		full      = (state_q != F_IDLE);
		div_start = (state_q == F_MAP);
		q_push    = (state_q == F_EMIT) && !q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			xc_q        <= xc;
			yc_q        <= yc;
			ent_q.mth   <= cfg.method;
			ent_q.pixel <= item.pixel;
			ent_q.fx    <= '0;
			ent_q.fy    <= '0;
			if (item.operation == OP_LOAD) begin
				ent_q.kind <= OP_LOAD;
				ent_q.xi   <= item.x_pos;
				ent_q.yi   <= item.y_pos;
			end else begin
				ent_q.kind <= OP_SAMPLE;
				ent_q.xi   <= xc >> cfg.scale;
				ent_q.yi   <= yc >> cfg.scale;
			end
		end else if (state_q == F_DIV && done_x && done_y) begin
			// A zero divisor means a one-pixel axis at 1x: position 0.
			if (lim_x == '0) begin
				ent_q.xi <= '0;
				ent_q.fx <= '0;
			end else begin
				ent_q.xi <= COORD_W'(pos_x >> FRAC_BITS);
				ent_q.fx <= FRAC_MAX'(pos_x[FRAC_BITS-1:0]);
			end
			if (lim_y == '0) begin
				ent_q.yi <= '0;
				ent_q.fy <= '0;
			end else begin
				ent_q.yi <= COORD_W'(pos_y >> FRAC_BITS);
				ent_q.fy <= FRAC_MAX'(pos_y[FRAC_BITS-1:0]);
			end
		end
	end

	assign q_data = ent_q;

endmodule

FILE: sv/imgup_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image upscaler queue
// Short show-ahead queue of classified words between front and back.
// ----------------------------------------------------------------------------
module imgup_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  imgup_pkg::entry_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output imgup_pkg::entry_t head
);
	import imgup_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PTR_W'(1);
			if (pop)  rd_q <= rd_q + PTR_W'(1);
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_data;
	end

endmodule

FILE: sv/imgup_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image upscaler back
// Pixel store, neighbor read sequencer, weighted sums, gain and saturation.
// ----------------------------------------------------------------------------
module imgup_back #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int FRAC_BITS  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  imgup_pkg::cfg_t      cfg,
	input  logic                 q_empty,
	output logic                 q_pop,
	input  imgup_pkg::entry_t    q_data,
	output logic                 empty,
	input  logic                 pop,
	output imgup_pkg::out_word_t result
);
	import imgup_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WGT_W  = 2 * FRAC_BITS + 3;
	localparam int PROD_W = WGT_W + PIX_W + 1;
	localparam int ROW_W  = 2 * FRAC_BITS + 13;
	localparam int ROWF_W = FRAC_BITS + 12;
	localparam int P2_W   = WGT_W + ROWF_W;
	localparam int ACC_W  = P2_W + 2;
	localparam int V_W    = FRAC_BITS + 11;
	localparam int NUM_W  = V_W + GAIN_W + 1;
	localparam int Q_W    = NUM_W - FRAC_BITS - 10;
	localparam int TC_W   = COORD_W + 2;
	localparam logic signed [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;
	localparam logic signed [NUM_W-1:0] RND = NUM_W'(1) << (FRAC_BITS + 9);

	back_state_t state_q, state_d;
	entry_t      ent_q;

	// Pixel store
	logic [PIX_W-1:0]  mem [DEPTH];
	logic              mem_we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [PIX_W-1:0]  pix_s1;

	// Weights and tap counters
	logic signed [WGT_W-1:0] wx_q [3];
	logic signed [WGT_W-1:0] wy_q [3];
	logic signed [WGT_W-1:0] wx_d [3];
	logic signed [WGT_W-1:0] wy_d [3];
	logic signed [WGT_W-1:0] sfx, sfy;
	logic [1:0]              last_i_q, last_j_q, last_i_d, last_j_d;
	logic [1:0]              i_q, j_q;
	logic                    upper_q, upper_d;
	logic                    quad_q;
	logic                    issue, eor, last_tap;

	// Tap position
	logic signed [2:0]      dx, dy;
	logic signed [TC_W-1:0] tx, ty, wmax, hmax;
	logic [COORD_W-1:0]     cx, cy;

	// Datapath stages
	logic                     v_s1, eor_s1, last_s1;
	logic signed [WGT_W-1:0]  a_s1, b_s1;
	logic                     v_s2, eor_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2, prod_c;
	logic signed [WGT_W-1:0]  b_s2;
	logic signed [ROW_W-1:0]  row_q, row_sum, row_sh;
	logic                     v_s3, last_s3;
	logic signed [ROWF_W-1:0] rowf_s3;
	logic signed [WGT_W-1:0]  b_s3;
	logic                     v_s4, last_s4;
	logic signed [P2_W-1:0]   p2_s4, p2_c;
	logic signed [ACC_W-1:0]  acc_q, acc_sum, acc_sh;
	logic                     v_s5;
	logic signed [V_W-1:0]    val_s5;
	logic                     v_s6;
	logic signed [NUM_W-1:0]  num_s6, num_c, num_r;
	logic signed [Q_W-1:0]    qv;
	logic                     out_valid_q;
	out_word_t                res_q;

	// ---------------------------------------------------------------- control
	assign issue    = (state_q == B_READ);
	assign eor      = (i_q == last_i_q);
	assign last_tap = eor && (j_q == last_j_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty && q_data.kind == OP_SAMPLE && !out_valid_q) state_d = B_PREP;
			end
			B_PREP:  state_d = B_READ;
			B_READ:  if (last_tap) state_d = B_DRAIN;
			B_DRAIN: if (v_s6) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = (state_q == B_IDLE) && !q_empty &&
		         (q_data.kind == OP_LOAD || !out_valid_q);
		mem_we = q_pop && (q_data.kind == OP_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------- weights
	assign sfx = $signed(WGT_W'(ent_q.fx[FRAC_BITS-1:0]));
	assign sfy = $signed(WGT_W'(ent_q.fy[FRAC_BITS-1:0]));

	always_comb begin
		upper_d  = (sfx + sfy) > ONE;
		last_i_d = 2'd0;
		last_j_d = 2'd0;
		for (int k = 0; k < 3; k++) begin
			wx_d[k] = '0;
			wy_d[k] = '0;
		end
		unique case (ent_q.mth)
			M_NEAREST: begin
				wx_d[0] = ONE;
				wy_d[0] = ONE;
			end
			M_BILINEAR: begin
				wx_d[0]  = ONE - sfx;
				wx_d[1]  = sfx;
				wy_d[0]  = ONE - sfy;
				wy_d[1]  = sfy;
				last_i_d = 2'd1;
				last_j_d = 2'd1;
			end
			M_QUADRATIC: begin
				// Lagrange weights for neighbors r-1, r, r+1, scaled by 2^(2F+1).
				wx_d[0]  = -(sfx * (ONE - sfx));
				wx_d[1]  = ((ONE + sfx) * (ONE - sfx)) <<< 1;
				wx_d[2]  = sfx * (ONE + sfx);
				wy_d[0]  = -(sfy * (ONE - sfy));
				wy_d[1]  = ((ONE + sfy) * (ONE - sfy)) <<< 1;
				wy_d[2]  = sfy * (ONE + sfy);
				last_i_d = 2'd2;
				last_j_d = 2'd2;
			end
			M_BARY: begin
				if (upper_d) begin
					wx_d[0] = sfx + sfy - ONE;
					wx_d[1] = ONE - sfy;
					wx_d[2] = ONE - sfx;
				end else begin
					wx_d[0] = ONE - sfx - sfy;
					wx_d[1] = sfx;
					wx_d[2] = sfy;
				end
				wy_d[0]  = ONE;
				last_i_d = 2'd2;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- taps
	always_comb begin
		dx = '0;
		dy = '0;
		unique case (ent_q.mth)
			M_NEAREST: ;
			M_BILINEAR: begin
				dx = $signed({1'b0, i_q});
				dy = $signed({1'b0, j_q});
			end
			M_QUADRATIC: begin
				dx = $signed({1'b0, i_q}) - 3'sd1;
				dy = $signed({1'b0, j_q}) - 3'sd1;
			end
			M_BARY: begin
				if (upper_q) begin
					dx = (i_q == 2'd0 || i_q == 2'd1) ? 3'sd1 : 3'sd0;
					dy = (i_q == 2'd0 || i_q == 2'd2) ? 3'sd1 : 3'sd0;
				end else begin
					dx = (i_q == 2'd1) ? 3'sd1 : 3'sd0;
					dy = (i_q == 2'd2) ? 3'sd1 : 3'sd0;
				end
			end
			default: ;
		endcase
	end

	// Neighbors clamp to the image edges.
	always_comb begin
		tx   = $signed({2'b00, ent_q.xi}) + TC_W'(dx);
		ty   = $signed({2'b00, ent_q.yi}) + TC_W'(dy);
		wmax = $signed(TC_W'(cfg.width) - TC_W'(1));
		hmax = $signed(TC_W'(cfg.height) - TC_W'(1));
		if (tx < 0) begin
			cx = '0;
		end else if (tx > wmax) begin
			cx = wmax[COORD_W-1:0];
		end else begin
			cx = tx[COORD_W-1:0];
		end
		if (ty < 0) begin
			cy = '0;
		end else if (ty > hmax) begin
			cy = hmax[COORD_W-1:0];
		end else begin
			cy = ty[COORD_W-1:0];
		end
	end

	assign raddr = ADDR_W'(cy * MAX_WIDTH + cx);
	assign waddr = ADDR_W'(q_data.yi * MAX_WIDTH + q_data.xi);

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= q_data.pixel;
		pix_s1 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) ent_q <= q_data;
		if (state_q == B_PREP) begin
			for (int k = 0; k < 3; k++) begin
				wx_q[k] <= wx_d[k];
				wy_q[k] <= wy_d[k];
			end
			upper_q  <= upper_d;
			quad_q   <= (ent_q.mth == M_QUADRATIC);
			last_i_q <= last_i_d;
			last_j_q <= last_j_d;
		end
		if (issue) begin
			a_s1    <= wx_q[i_q];
			b_s1    <= wy_q[j_q];
			eor_s1  <= eor;
			last_s1 <= last_tap;
		end
		prod_s2 <= prod_c;
		b_s2    <= b_s1;
		eor_s2  <= eor_s1;
		last_s2 <= last_s1;
		p2_s4   <= p2_c;
		last_s4 <= last_s3;
		num_s6  <= num_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else if (state_q == B_PREP) begin
			i_q <= '0;
			j_q <= '0;
		end else if (issue) begin
			if (eor) begin
				i_q <= '0;
				j_q <= j_q + 2'd1;
			end else begin
				i_q <= i_q + 2'd1;
			end
		end
	end

	// ---------------------------------------------------------------- sums
	assign prod_c  = a_s1 * $signed({1'b0, pix_s1});
	assign row_sum = row_q + ROW_W'(prod_s2);
	assign row_sh  = quad_q ? (row_sum >>> (FRAC_BITS + 1)) : row_sum;
	assign p2_c    = b_s3 * rowf_s3;
	assign acc_sum = acc_q + ACC_W'(p2_s4);
	assign acc_sh  = quad_q ? (acc_sum >>> (2 * FRAC_BITS + 1)) : (acc_sum >>> FRAC_BITS);
	assign num_c   = val_s5 * $signed({1'b0, cfg.gain});
	assign num_r   = num_s6 + RND;
	assign qv      = Q_W'(num_r >>> (FRAC_BITS + 10));

	always_ff @(posedge clk) begin
		if (state_q == B_PREP) begin
			row_q <= '0;
			acc_q <= '0;
		end else begin
			if (v_s2) begin
				if (eor_s2) begin
					row_q   <= '0;
					rowf_s3 <= ROWF_W'(row_sh);
					b_s3    <= b_s2;
					last_s3 <= last_s2;
				end else begin
					row_q <= row_sum;
				end
			end
			if (v_s4) begin
				if (last_s4) begin
					acc_q  <= '0;
					val_s5 <= V_W'(acc_sh);
				end else begin
					acc_q <= acc_sum;
				end
			end
		end
		if (v_s6) begin
			if (qv < 0) begin
				res_q.intensity <= '0;
				res_q.clipped   <= 1'b1;
			end else if (qv > Q_W'(255)) begin
				res_q.intensity <= '1;
				res_q.clipped   <= 1'b1;
			end else begin
				res_q.intensity <= qv[PIX_W-1:0];
				res_q.clipped   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && eor_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && last_s4;
			v_s6 <= v_s5;
			if (v_s6) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty  = !out_valid_q;
	assign result = res_q;

endmodule

FILE: sv/image_upscale_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image upscale interpolator core
// Grayscale upscaler by 1, 2, 4 or 8 with four interpolation methods.
// ----------------------------------------------------------------------------
// Input words enter through push/full. A load word writes one source pixel;
// a sample word asks for one output pixel and yields one result word, which
// waits on the result ports while empty is low and leaves on pop. The
// user writes registers via cfg_write/cfg_index/cfg_data when idle, unchecked.
//
// The front registers a load or a nearest sample and hands it to the queue;
// a sample for the mapped methods first goes through the bit-serial
// position dividers (x and y run side by side). The back then sets up its
// weights and reads one neighbor per cycle from the pixel store: 1, 4, 9
// or 3 reads for nearest, bilinear, quadratic and triangle, and the sums
// pass through the pipeline into the output register.
// A four-word queue decouples the two halves, so loads keep flowing while a
// result waits; a stalled receiver blocks the next sample and words behind it.
// Reset sets the registers to their defaults and empties both halves; the
// pixel store is not cleared and must be loaded before it is sampled.
// ----------------------------------------------------------------------------
module image_upscale_interpolator_core #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  imgup_pkg::in_word_t                 item,
	output logic                                empty,
	input  logic                                pop,
	output imgup_pkg::out_word_t                result,
	input  logic                                cfg_write,
	input  logic [imgup_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [imgup_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import imgup_pkg::*;

	logic [DIM_W-1:0]   width_q, height_q;
	logic [SCALE_W-1:0] scale_q;
	method_t            method_q;
	logic [GAIN_W-1:0]  gain_q;
	cfg_t               cfg;
	logic               q_push, q_full, q_pop, q_empty;
	entry_t             q_in, q_head;

	// Register file; writes beyond the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
			scale_q  <= '0;
			method_q <= M_NEAREST;
			gain_q   <= 12'd1024;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
				REG_METHOD: method_q <= method_t'(cfg_data[1:0]);
				REG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero dimension acts as one; a dimension beyond the store acts as
	// the store's size.
	always_comb begin
		if (width_q == '0) begin
			cfg.width = DIM_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			cfg.width = DIM_W'(MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = DIM_W'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			cfg.height = DIM_W'(MAX_HEIGHT);
		end else begin
			cfg.height = height_q;
		end
		cfg.scale  = scale_q;
		cfg.method = method_q;
		cfg.gain   = gain_q;
	end

	imgup_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS))
	u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.push(push), .full(full), .item(item),
		.q_push(q_push), .q_full(q_full), .q_data(q_in)
	);

	imgup_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .empty(q_empty), .head(q_head)
	);

	imgup_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS))
	u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.q_empty(q_empty), .q_pop(q_pop), .q_data(q_head),
		.empty(empty), .pop(pop), .result(result)
	);

	// An accepted sample moves the front out of idle, so full is raised.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && item.operation == OP_SAMPLE) |=> full)
		else $error("front free right after a sample");

	// The front never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue overflow");

	// The back never takes a word from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue underflow");

	// A saturated result sits at one of the two rails.
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.clipped) |-> (result.intensity == 8'd0 || result.intensity == 8'd255))
		else $error("clipped result off the rails");

endmodule

FILE: dv/image_upscale_interpolator_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image upscale interpolator core test
// Loads small source images, samples them under many register settings and
// checks every result word against an in-bench prediction of the upscaler.
// ----------------------------------------------------------------------------
module image_upscale_interpolator_core_test;
	import imgup_pkg::*;

	localparam int MAXW = 64;
	localparam int MAXH = 64;
	localparam int FB = 8;
	localparam int ONE = 1 << FB;
	localparam int WATCHDOG_LIMIT = 4000;
	// Cycles that cover a sample still in flight when no result is pending.
	localparam int SETTLE_CYCLES = 60;

	// Holds the expected result words and a private copy of the pixel store
	// and register file, and computes each sample's output pixel.
	class upscale_scoreboard;
		bit [PIX_W-1:0] pix_copy [MAXW*MAXH];
		int unsigned width_r, height_r, scale_r, method_r, gain_r;
		out_word_t pending_px[$];
		int mismatches;

		function void reset_regs();
			width_r = 64;
			height_r = 64;
			scale_r = 0;
			method_r = M_NEAREST;
			gain_r = 1024;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, int unsigned val);
			case (idx)
				REG_WIDTH: width_r = val & 'h7F;
				REG_HEIGHT: height_r = val & 'h7F;
				REG_SCALE: scale_r = val & 'h3;
				REG_METHOD: method_r = val & 'h3;
				REG_GAIN: gain_r = val & 'hFFF;
				default: ;
			endcase
		endfunction

		function longint fetch(longint x, longint y, int unsigned w, int unsigned h);
			longint cx, cy;
			cx = (x < 0) ? 0 : (x > w - 1) ? w - 1 : x;
			cy = (y < 0) ? 0 : (y > h - 1) ? h - 1 : y;
			return longint'(pix_copy[cy * MAXW + cx]);
		endfunction

		function longint map_axis(longint o, longint n, int unsigned s);
			longint den;
			den = (n << s) - 1;
			if (den == 0)
				return 0;
			return ((o * (n - 1)) << FB) / den;
		endfunction

		// Notes one accepted input word: a load updates the store copy and a
		// sample queues the output pixel it must produce.
		function void note_word(in_word_t wd);
			int unsigned w, h, s;
			longint x, y, v, px, py, r, c, fx, fy, top, bot, acc, row, q, pb, pc;
			longint wx[3], wy[3];
			out_word_t res;
			if (wd.operation == OP_LOAD) begin
				if (wd.x_pos < MAXW && wd.y_pos < MAXH)
					pix_copy[wd.y_pos * MAXW + wd.x_pos] = wd.pixel;
				return;
			end
			w = (width_r < 1) ? 1 : (width_r > MAXW) ? MAXW : width_r;
			h = (height_r < 1) ? 1 : (height_r > MAXH) ? MAXH : height_r;
			s = scale_r;
			x = wd.x_pos;
			y = wd.y_pos;
			if (x > (w << s) - 1)
				x = (w << s) - 1;
			if (y > (h << s) - 1)
				y = (h << s) - 1;
			if (method_r == M_NEAREST) begin
				v = fetch(x >> s, y >> s, w, h) * ONE;
			end else begin
				px = map_axis(x, w, s);
				py = map_axis(y, h, s);
				r = px >> FB;
				c = py >> FB;
				fx = px & (ONE - 1);
				fy = py & (ONE - 1);
				if (method_r == M_BILINEAR) begin
					top = fetch(r, c, w, h) * (ONE - fx) + fetch(r + 1, c, w, h) * fx;
					bot = fetch(r, c + 1, w, h) * (ONE - fx) + fetch(r + 1, c + 1, w, h) * fx;
					v = (top * (ONE - fy) + bot * fy) >>> FB;
				end else if (method_r == M_QUADRATIC) begin
					wx[0] = -fx * (ONE - fx);
					wx[1] = 2 * (ONE + fx) * (ONE - fx);
					wx[2] = fx * (ONE + fx);
					wy[0] = -fy * (ONE - fy);
					wy[1] = 2 * (ONE + fy) * (ONE - fy);
					wy[2] = fy * (ONE + fy);
					acc = 0;
					for (int j = 0; j < 3; j++) begin
						row = 0;
						for (int i = 0; i < 3; i++)
							row += wx[i] * fetch(r - 1 + i, c - 1 + j, w, h);
						acc += wy[j] * (row >>> (FB + 1));
					end
					v = acc >>> (2 * FB + 1);
				end else begin
					pb = fetch(r + 1, c, w, h);
					pc = fetch(r, c + 1, w, h);
					if (fx + fy <= ONE)
						v = (ONE - fx - fy) * fetch(r, c, w, h) + fx * pb + fy * pc;
					else
						v = (fx + fy - ONE) * fetch(r + 1, c + 1, w, h)
							+ (ONE - fy) * pb + (ONE - fx) * pc;
				end
			end
			q = (v * longint'(gain_r) + (longint'(1) << (FB + 9))) >>> (FB + 10);
			if (q < 0) begin
				res.intensity = 0;
				res.clipped = 1'b1;
			end else if (q > 255) begin
				res.intensity = 255;
				res.clipped = 1'b1;
			end else begin
				res.intensity = q[7:0];
				res.clipped = 1'b0;
			end
			pending_px.push_back(res);
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp_w;
			if (pending_px.size() == 0) begin
				$error("result word with no sample outstanding: intensity %0d clipped %0d",
					got.intensity, got.clipped);
				mismatches++;
				return;
			end
			exp_w = pending_px.pop_front();
			if (got.intensity !== exp_w.intensity) begin
				$error("intensity: expected %0d, actual %0d", exp_w.intensity, got.intensity);
				mismatches++;
			end
			if (got.clipped !== exp_w.clipped) begin
				$error("clipped: expected %0d, actual %0d", exp_w.clipped, got.clipped);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_word_t item;
	logic empty;
	logic pop;
	out_word_t result;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	upscale_scoreboard sb;
	// Which source pixels have been loaded; samples only touch loaded ones.
	bit loaded [MAXH][MAXW];
	// Sender gaps are suppressed while set, giving back-to-back words.
	bit burst_mode;
	// Asks the result side for one long stall.
	bit hold_request;
	int idle_cycles;

	image_upscale_interpolator_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Result words are checked at the edge where they are taken.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(result);
	end

	// The watchdog ends the run when neither side has moved a word for too
	// long; a hung block shows up here rather than as a silent hang.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_write)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** image_upscale_interpolator_core: FAILED **");
			$finish;
		end
	end

	// The result side takes words with random gaps, and once a long stall
	// that lets the internal queue fill so the block must raise full.
	initial begin : result_side
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 10);
			if (burst_mode)
				gap = 0;
			if (hold_request) begin
				gap = 300;
				hold_request = 1'b0;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
		end
	end

	task automatic send_word(in_word_t wd);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= wd;
		do
			@(posedge clk);
		while (full);
		sb.note_word(wd);
		if (wd.operation == OP_LOAD && wd.x_pos < MAXW && wd.y_pos < MAXH)
			loaded[wd.y_pos][wd.x_pos] = 1'b1;
	endtask

	// Stops offering words and waits until every sample has been answered,
	// then a little longer for anything that is still in flight.
	task automatic drain();
		push <= 1'b0;
		while (sb.pending_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic send_load(int unsigned x, int unsigned y, int unsigned p);
		in_word_t wd;
		wd.operation = OP_LOAD;
		wd.x_pos = x[COORD_W-1:0];
		wd.y_pos = y[COORD_W-1:0];
		wd.pixel = p[PIX_W-1:0];
		send_word(wd);
	endtask

	task automatic send_sample(int unsigned x, int unsigned y);
		in_word_t wd;
		int unsigned p;
		p = $urandom_range(0, 255);
		wd.operation = OP_SAMPLE;
		wd.x_pos = x[COORD_W-1:0];
		wd.y_pos = y[COORD_W-1:0];
		wd.pixel = p[PIX_W-1:0];
		send_word(wd);
	endtask

	// One phase: program all five registers while idle, make sure the region
	// the samples can touch is loaded, then mix samples with loads.
	task automatic run_phase(int unsigned w_raw, int unsigned h_raw, int unsigned s,
		method_t m, int unsigned g, int n_words, bit checker_fill);
		int unsigned ew, eh, ox, oy, sel;
		drain();
		write_reg(REG_WIDTH, w_raw);
		write_reg(REG_HEIGHT, h_raw);
		write_reg(REG_SCALE, s);
		write_reg(REG_METHOD, m);
		write_reg(REG_GAIN, g);
		cfg_write <= 1'b0;
		ew = (w_raw < 1) ? 1 : (w_raw > MAXW) ? MAXW : w_raw;
		eh = (h_raw < 1) ? 1 : (h_raw > MAXH) ? MAXH : h_raw;
		ox = ew << s;
		oy = eh << s;
		for (int y = 0; y < eh; y++)
			for (int x = 0; x < ew; x++)
				if (checker_fill)
					send_load(x, y, ((x + y) % 2) ? 255 : 0);
				else if (!loaded[y][x] || $urandom_range(0, 7) == 0)
					send_load(x, y, $urandom_range(0, 255));
		// Corners of the output image and coordinates past its edge.
		send_sample(0, 0);
		send_sample(511, 511);
		send_sample(ox - 1, 0);
		send_sample(0, 511);
		for (int k = 0; k < n_words; k++) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				// Outside the store, so the block drops it.
				send_load($urandom_range(MAXW, 511), $urandom_range(0, 511),
					$urandom_range(0, 255));
			else if (sel == 1)
				send_load($urandom_range(0, MAXW - 1), $urandom_range(0, MAXH - 1),
					$urandom_range(0, 255));
			else if (sel == 2)
				send_sample($urandom_range(0, 511), $urandom_range(0, 511));
			else
				send_sample($urandom_range(0, ox - 1), $urandom_range(0, oy - 1));
		end
	endtask

	initial begin : stimulus
		method_t m;
		sb = new();
		sb.reset_regs();
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_write = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		burst_mode = 1'b1;
		hold_request = 1'b0;
		idle_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: a black and white checkerboard, each method once.
		run_phase(3, 2, 1, M_NEAREST, 1024, 2, 1'b1);
		run_phase(3, 2, 1, M_BILINEAR, 1024, 2, 1'b0);
		run_phase(3, 2, 2, M_QUADRATIC, 1024, 2, 1'b0);
		run_phase(3, 2, 3, M_BARY, 1024, 2, 1'b0);
		burst_mode = 1'b0;

		// Register extremes under every method.
		for (int i = 0; i < 4; i++) begin
			m = method_t'(i);
			run_phase(0, 0, 3, m, 1024, 4, 1'b0);
			run_phase(1, 1, 0, m, 4095, 3, 1'b0);
			run_phase(127, 1, 2, m, 4095, 7, 1'b0);
			run_phase(1, 64, 3, m, 0, 5, 1'b0);
			run_phase(5, 7, 2, m, 2048, 8, 1'b0);
			run_phase(64, 2, 0, m, 1, 5, 1'b0);
		end

		// Long receiver stall while samples keep coming, so full must rise.
		run_phase(4, 4, 1, M_QUADRATIC, 1500, 0, 1'b0);
		hold_request = 1'b1;
		for (int k = 0; k < 12; k++)
			send_sample($urandom_range(0, 7), $urandom_range(0, 7));

		// Random settings on small images.
		for (int p = 0; p < 3; p++) begin
			burst_mode = (p % 5 == 2);
			run_phase($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(0, 3),
				method_t'($urandom_range(0, 3)), $urandom_range(0, 4095), 22, 1'b0);
			if (p == 1) begin
				// Sender waits for every answer before going on.
				drain();
				run_phase($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(0, 3),
					method_t'($urandom_range(0, 3)), $urandom_range(700, 2048), 10, 1'b0);
			end
		end
		burst_mode = 1'b0;

		drain();
		if (sb.pending_px.size() != 0) begin
			$error("%0d expected result words never arrived", sb.pending_px.size());
			sb.mismatches++;
		end
		if (sb.mismatches == 0)
			$display("** image_upscale_interpolator_core: PASSED **");
		else
			$display("** image_upscale_interpolator_core: FAILED **");
		$finish;
	end

endmodule
